// ----- rtl/lkr_pkg.sv -----
package lkr_pkg;

  // Operation codes carried in the mode field
  localparam logic [1:0] MODE_RECORD = 2'd0;
  localparam logic [1:0] MODE_SET    = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;
  localparam logic [1:0] MODE_EVICT  = 2'd3;

  // Result status codes
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_RANGE     = 3'd1;
  localparam logic [2:0] STAT_UNTRACKED = 3'd2;
  localparam logic [2:0] STAT_PINNED    = 3'd3;
  localparam logic [2:0] STAT_NOVICTIM  = 3'd4;

  // Configuration register indexes
  localparam logic CFG_FRAMES_IN_USE = 1'b0;
  localparam logic CFG_K_THRESHOLD   = 1'b1;

  // Field widths fixed by the interface
  localparam int MODE_W  = 2;
  localparam int ID_W    = 8;
  localparam int STAT_W  = 3;
  localparam int COUNT_W = 7;
  localparam int FIU_W   = 7;
  localparam int K_W     = 4;
  localparam int CFG_A_W = 1;
  localparam int CFG_D_W = 7;

  // Per-frame access counter
  localparam int                ACC_W   = 4;
  localparam logic [ACC_W-1:0]  ACC_MAX = 4'd15;

  // Reset values of the configuration registers
  localparam logic [FIU_W-1:0] FIU_RESET = 7'd64;
  localparam logic [K_W-1:0]   K_RESET   = 4'd2;

endpackage

// ----- rtl/lkr_in_if.sv -----
interface lkr_in_if;
  logic                        valid;
  logic                        ready;
  logic [lkr_pkg::MODE_W-1:0]  mode;
  logic [lkr_pkg::ID_W-1:0]    frame_sel;
  logic                        evictable_flag;

  modport source (output valid, mode, frame_sel, evictable_flag, input ready);
  modport sink   (input valid, mode, frame_sel, evictable_flag, output ready);
endinterface

// ----- rtl/lkr_out_if.sv -----
interface lkr_out_if;
  logic                         valid;
  logic                         ready;
  logic [lkr_pkg::STAT_W-1:0]   status;
  logic [lkr_pkg::ID_W-1:0]     victim_frame;
  logic [lkr_pkg::COUNT_W-1:0]  evictable_count;

  modport source (output valid, status, victim_frame, evictable_count, input ready);
  modport sink   (input valid, status, victim_frame, evictable_count, output ready);
endinterface

// ----- rtl/lkr_victim_sel.sv -----
// Shared compare unit: keeps the best history and best cached candidate
// seen so far during an evict scan. One wide compare per cycle.
module lkr_victim_sel #(
  parameter int IDX_W     = 6,
  parameter int TIME_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 clear,
  input  logic                 cand_valid,
  input  logic [IDX_W-1:0]     cand_idx,
  input  logic                 cand_hist,
  input  logic [TIME_BITS-1:0] cand_time,
  output logic                 hist_found,
  output logic [IDX_W-1:0]     hist_idx,
  output logic                 cache_found,
  output logic [IDX_W-1:0]     cache_idx
);

  logic                 hist_found_r, cache_found_r;
  logic [IDX_W-1:0]     hist_idx_r, cache_idx_r;
  logic [TIME_BITS-1:0] hist_time_r, cache_time_r;
  logic [TIME_BITS-1:0] best_time;
  logic                 best_found;
  logic                 take;

  // Strict less-than: on equal times the earlier (lower) frame id stays
  always_comb begin
    best_time  = cand_hist ? hist_time_r : cache_time_r;
    best_found = cand_hist ? hist_found_r : cache_found_r;
    take       = cand_valid && (!best_found || (cand_time < best_time));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_found_r  <= 1'b0;
      cache_found_r <= 1'b0;
    end else if (clear) begin
      hist_found_r  <= 1'b0;
      cache_found_r <= 1'b0;
    end else if (take && cand_hist) begin
      hist_found_r  <= 1'b1;
    end else if (take) begin
      cache_found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && cand_hist) begin
      hist_idx_r  <= cand_idx;
      hist_time_r <= cand_time;
    end else if (take) begin
      cache_idx_r  <= cand_idx;
      cache_time_r <= cand_time;
    end
  end

  assign hist_found  = hist_found_r;
  assign hist_idx    = hist_idx_r;
  assign cache_found = cache_found_r;
  assign cache_idx   = cache_idx_r;

endmodule

// ----- rtl/lru_k_frame_replacer_unit.sv -----
// Channel   Dir  Payload                                       Handshake
// in_ch     in   mode, frame_sel, evictable_flag               valid/ready
// out_ch    out  status, victim_frame, evictable_count         valid/ready
// cfg_*     in   cfg_addr (register index), cfg_wdata          cfg_we, no wait
//
// Record of a tracked frame, set-evictable and remove pass through accept,
// decode/read, update and result; the first record of a frame and range and
// tracking rejects skip the update step.
// Evict reads one record per cycle from the single-port record memory and
// feeds it to the shared time comparator.
// One item is in flight at a time; in_ch.ready is high only while idle.
// A finished result waits in the output register; a new item may be taken
// meanwhile, and it stalls in its last step until that register drains.
// Synchronous active-low reset clears control state and the valid bits;
// the record memory is written whenever a frame becomes tracked.
module lru_k_frame_replacer_unit #(
  parameter int MAX_FRAMES = 64,
  parameter int TIME_BITS  = 48
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lkr_pkg::CFG_A_W-1:0]    cfg_addr,
  input  logic [lkr_pkg::CFG_D_W-1:0]    cfg_wdata,
  lkr_in_if.sink                         in_ch,
  lkr_out_if.source                      out_ch
);

  localparam int FW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int TOT_W = $clog2(MAX_FRAMES + 1);
  localparam int REC_W = 1 + lkr_pkg::ACC_W + 2 * TIME_BITS;

  // Record layout: {evictable, access count, first access, last access}
  localparam int LAST_LO  = 0;
  localparam int FIRST_LO = TIME_BITS;
  localparam int ACC_LO   = 2 * TIME_BITS;
  localparam int EV_BIT   = 2 * TIME_BITS + lkr_pkg::ACC_W;

  localparam logic [FW-1:0]                LAST_IDX  = FW'(MAX_FRAMES - 1);
  localparam logic [lkr_pkg::ID_W:0]       MAX_LIMIT = (lkr_pkg::ID_W + 1)'(MAX_FRAMES);
  localparam logic [TIME_BITS-1:0]         CLOCK_MAX = '1;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_ISSUE  = 7'b0000010,
    S_UPD    = 7'b0000100,
    S_SCAN   = 7'b0001000,
    S_DRAIN  = 7'b0010000,
    S_FINISH = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration
  logic [lkr_pkg::FIU_W-1:0] fiu_r;
  logic [lkr_pkg::K_W-1:0]   k_r;

  // Captured item
  logic [1:0]                mode_r, mode_nxt;
  logic [lkr_pkg::ID_W-1:0]  id_r, id_nxt;
  logic                      flag_r, flag_nxt;

  // Tracking state
  logic [MAX_FRAMES-1:0]     valid_r, valid_nxt;
  logic [TOT_W-1:0]          total_r, total_nxt;
  logic [TIME_BITS-1:0]      clock_r, clock_nxt, clock_inc;

  // Record memory
  logic [REC_W-1:0]          rec_mem [MAX_FRAMES];
  logic [REC_W-1:0]          rd_q;
  logic [REC_W-1:0]          mem_wdata;
  logic [FW-1:0]             mem_addr;
  logic                      mem_we, mem_re;

  // Scan pipeline
  logic [FW-1:0]             scan_idx_r, scan_idx_nxt;
  logic                      p_vld_r, p_vld_nxt;
  logic [FW-1:0]             p_idx_r, p_idx_nxt;
  logic                      sel_clear;

  // Shared comparator results
  logic                      hist_found, cache_found;
  logic [FW-1:0]             hist_idx, cache_idx, victim_idx;

  // Result staging and output register
  logic [lkr_pkg::STAT_W-1:0]  res_status_r, res_status_nxt;
  logic [lkr_pkg::ID_W-1:0]    res_victim_r, res_victim_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [lkr_pkg::STAT_W-1:0]  out_status_r, out_status_nxt;
  logic [lkr_pkg::ID_W-1:0]    out_victim_r, out_victim_nxt;
  logic [lkr_pkg::COUNT_W-1:0] out_count_r, out_count_nxt;

  // Decoded fields
  logic [FW-1:0]             id_idx;
  logic                      in_rng;
  logic                      rd_ev;
  logic [lkr_pkg::ACC_W-1:0] rd_acc, acc_inc;
  logic [TIME_BITS-1:0]      rd_first, rd_last;
  logic                      slot_free;
  logic [15:0]               total_ext;

  assign id_idx    = id_r[FW-1:0];
  assign in_rng    = ({1'b0, id_r} < MAX_LIMIT) && (id_r < {1'b0, fiu_r});
  assign rd_ev     = rd_q[EV_BIT];
  assign rd_acc    = rd_q[ACC_LO +: lkr_pkg::ACC_W];
  assign rd_first  = rd_q[FIRST_LO +: TIME_BITS];
  assign rd_last   = rd_q[LAST_LO +: TIME_BITS];
  assign acc_inc   = (rd_acc == lkr_pkg::ACC_MAX) ? rd_acc : rd_acc + 1'b1;
  assign clock_inc = (clock_r == CLOCK_MAX) ? clock_r : clock_r + 1'b1;
  assign slot_free = !out_valid_r || out_ch.ready;
  assign total_ext = 16'(total_r);
  assign victim_idx = hist_found ? hist_idx : cache_idx;

  // Shared comparator: history frames rank by first access, cached by last
  lkr_victim_sel #(
    .IDX_W     (FW),
    .TIME_BITS (TIME_BITS)
  ) u_sel (
    .clk         (clk),
    .rst_n       (rst_n),
    .clear       (sel_clear),
    .cand_valid  (p_vld_r && valid_r[p_idx_r] && rd_ev),
    .cand_idx    (p_idx_r),
    .cand_hist   (rd_acc < k_r),
    .cand_time   ((rd_acc < k_r) ? rd_first : rd_last),
    .hist_found  (hist_found),
    .hist_idx    (hist_idx),
    .cache_found (cache_found),
    .cache_idx   (cache_idx)
  );

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    id_nxt         = id_r;
    flag_nxt       = flag_r;
    valid_nxt      = valid_r;
    total_nxt      = total_r;
    clock_nxt      = clock_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_addr       = id_idx;
    mem_wdata      = rd_q;
    scan_idx_nxt   = scan_idx_r;
    p_vld_nxt      = 1'b0;
    p_idx_nxt      = scan_idx_r;
    sel_clear      = 1'b0;
    res_status_nxt = res_status_r;
    res_victim_nxt = res_victim_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_victim_nxt = out_victim_r;
    out_count_nxt  = out_count_r;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          mode_nxt  = in_ch.mode;
          id_nxt    = in_ch.frame_sel;
          flag_nxt  = in_ch.evictable_flag;
          state_nxt = S_ISSUE;
        end
      end

      S_ISSUE: begin
        res_status_nxt = lkr_pkg::STAT_OK;
        res_victim_nxt = '0;
        if (mode_r == lkr_pkg::MODE_EVICT) begin
          sel_clear    = 1'b1;
          scan_idx_nxt = '0;
          state_nxt    = S_SCAN;
        end else if (!in_rng) begin
          res_status_nxt = lkr_pkg::STAT_RANGE;
          state_nxt      = S_DONE;
        end else if (mode_r != lkr_pkg::MODE_RECORD && !valid_r[id_idx]) begin
          res_status_nxt = lkr_pkg::STAT_UNTRACKED;
          state_nxt      = S_DONE;
        end else if (mode_r == lkr_pkg::MODE_RECORD && !valid_r[id_idx]) begin
          // New frame: tracked, evictable, one access at the advanced clock
          clock_nxt         = clock_inc;
          mem_we            = 1'b1;
          mem_wdata         = {1'b1, lkr_pkg::ACC_W'(1), clock_inc, clock_inc};
          valid_nxt[id_idx] = 1'b1;
          total_nxt         = total_r + 1'b1;
          state_nxt         = S_DONE;
        end else begin
          if (mode_r == lkr_pkg::MODE_RECORD) begin
            clock_nxt = clock_inc;
          end
          mem_re    = 1'b1;
          state_nxt = S_UPD;
        end
      end

      S_UPD: begin
        case (mode_r)
          lkr_pkg::MODE_RECORD: begin
            mem_we    = 1'b1;
            mem_wdata = {rd_ev, acc_inc, rd_first, clock_r};
          end
          lkr_pkg::MODE_SET: begin
            mem_we    = 1'b1;
            mem_wdata = {flag_r, rd_acc, rd_first, rd_last};
            if (flag_r && !rd_ev) begin
              total_nxt = total_r + 1'b1;
            end else if (!flag_r && rd_ev && total_r != '0) begin
              total_nxt = total_r - 1'b1;
            end
          end
          lkr_pkg::MODE_REMOVE: begin
            if (!rd_ev) begin
              res_status_nxt = lkr_pkg::STAT_PINNED;
            end else begin
              valid_nxt[id_idx] = 1'b0;
              if (total_r != '0) begin
                total_nxt = total_r - 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
        state_nxt = S_DONE;
      end

      S_SCAN: begin
        // Issue one record read per cycle; the compare follows in the next cycle
        mem_re    = 1'b1;
        mem_addr  = scan_idx_r;
        p_vld_nxt = 1'b1;
        p_idx_nxt = scan_idx_r;
        if (scan_idx_r == LAST_IDX) begin
          state_nxt = S_DRAIN;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end

      S_DRAIN: begin
        state_nxt = S_FINISH;
      end

      S_FINISH: begin
        if (hist_found || cache_found) begin
          valid_nxt[victim_idx] = 1'b0;
          if (total_r != '0) begin
            total_nxt = total_r - 1'b1;
          end
          res_victim_nxt = lkr_pkg::ID_W'(victim_idx);
        end else begin
          res_status_nxt = lkr_pkg::STAT_NOVICTIM;
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        // Hold until the output register is free
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_victim_nxt = res_victim_r;
          out_count_nxt  = total_ext[lkr_pkg::COUNT_W-1:0];
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      total_r     <= '0;
      clock_r     <= '0;
      p_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
      fiu_r       <= lkr_pkg::FIU_RESET;
      k_r         <= lkr_pkg::K_RESET;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      total_r     <= total_nxt;
      clock_r     <= clock_nxt;
      p_vld_r     <= p_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_addr == lkr_pkg::CFG_FRAMES_IN_USE) begin
        fiu_r <= cfg_wdata;
      end
      if (cfg_we && cfg_addr == lkr_pkg::CFG_K_THRESHOLD) begin
        k_r <= cfg_wdata[lkr_pkg::K_W-1:0];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    id_r         <= id_nxt;
    flag_r       <= flag_nxt;
    scan_idx_r   <= scan_idx_nxt;
    p_idx_r      <= p_idx_nxt;
    res_status_r <= res_status_nxt;
    res_victim_r <= res_victim_nxt;
    out_status_r <= out_status_nxt;
    out_victim_r <= out_victim_nxt;
    out_count_r  <= out_count_nxt;
  end

  // Record memory: one port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      rec_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= rec_mem[mem_addr];
    end
  end

  assign in_ch.ready            = (state_r == S_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.victim_frame    = out_victim_r;
  assign out_ch.evictable_count = out_count_r;

`ifndef SYNTHESIS
  a_total_le_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= $countones(valid_r))
    else $error("evictable count exceeds tracked frames");

  a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    p_vld_r |-> (state_r == S_SCAN || state_r == S_DRAIN))
    else $error("scan compare outside evict scan");

  a_victim_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && (hist_found || cache_found)) |=> !valid_r[$past(victim_idx)])
    else $error("evicted frame still tracked");

  a_clock_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> clock_r >= $past(clock_r))
    else $error("access clock moved backward");

  a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != lkr_pkg::STAT_OK) |-> out_ch.victim_frame == '0)
    else $error("victim reported on failed operation");
`endif

endmodule

// ----- verif/tb_lru_k_frame_replacer_unit.sv -----
`timescale 1ns / 100ps

module tb_lru_k_frame_replacer_unit;

  localparam int MAX_FRAMES = 64;
  localparam int TIME_BITS  = 48;
  localparam int PHASES     = 9;
  localparam int PHASE_OPS  = 105;

  // One operation on the input channel
  typedef struct packed {
    logic [lkr_pkg::MODE_W-1:0] mode;
    logic [lkr_pkg::ID_W-1:0]   frame_sel;
    logic                       evictable_flag;
  } replacer_op_t;

  // One result on the output channel
  typedef struct packed {
    logic [lkr_pkg::STAT_W-1:0]  status;
    logic [lkr_pkg::ID_W-1:0]    victim_frame;
    logic [lkr_pkg::COUNT_W-1:0] evictable_count;
  } replacer_result_t;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_we;
  logic [lkr_pkg::CFG_A_W-1:0]  cfg_addr;
  logic [lkr_pkg::CFG_D_W-1:0]  cfg_wdata;

  lkr_in_if  in_ch ();
  lkr_out_if out_ch ();

  lru_k_frame_replacer_unit #(
    .MAX_FRAMES (MAX_FRAMES),
    .TIME_BITS  (TIME_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // 8 ns period
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------
  // Shadow of the replacer: per-frame records, access clock, evictable
  // total and the two configuration registers.
  // ---------------------------------------------------------------------
  logic                         trk_valid     [MAX_FRAMES] = '{default: 1'b0};
  logic                         trk_evictable [MAX_FRAMES] = '{default: 1'b0};
  logic [lkr_pkg::ACC_W-1:0]    hits          [MAX_FRAMES];
  logic [TIME_BITS-1:0]         first_seen    [MAX_FRAMES];
  logic [TIME_BITS-1:0]         last_seen     [MAX_FRAMES];
  logic [TIME_BITS-1:0]         tick          = '0;
  int unsigned                  evictable_num = 0;
  logic [lkr_pkg::FIU_W-1:0]    fiu_cfg       = lkr_pkg::FIU_RESET;
  logic [lkr_pkg::K_W-1:0]      k_cfg         = lkr_pkg::K_RESET;

  replacer_op_t     op_q[$];       // operations waiting for the driver
  replacer_result_t outcome_q[$];  // predicted results, oldest first
  replacer_op_t     cur_op;        // operation currently offered
  replacer_result_t want;
  int               items_queued = 0;
  int               items_taken  = 0;
  int               results_seen = 0;
  int               err_cnt      = 0;
  int               stall_left   = 0;
  bit               backlog_done = 1'b0;

  // Drop a tracked frame and keep the evictable total in step
  function automatic void untrack(int f);
    if (trk_evictable[f] && evictable_num > 0) evictable_num--;
    trk_valid[f]     = 1'b0;
    trk_evictable[f] = 1'b0;
  endfunction

  // Apply one accepted operation to the shadow and return its result
  function automatic replacer_result_t replacer_outcome(replacer_op_t op);
    replacer_result_t res;
    int               lim;
    int               f;
    int               hist;
    int               cache;
    res.status       = lkr_pkg::STAT_OK;
    res.victim_frame = '0;
    lim = (fiu_cfg > MAX_FRAMES) ? MAX_FRAMES : int'(fiu_cfg);
    f   = int'(op.frame_sel);
    if (op.mode == lkr_pkg::MODE_EVICT) begin
      // Scan every tracked frame, including those above a lowered limit;
      // strict compares keep the lowest id on a tie.
      hist  = -1;
      cache = -1;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        if (trk_valid[i] && trk_evictable[i]) begin
          if (hits[i] < k_cfg) begin
            if (hist < 0 || first_seen[i] < first_seen[hist]) hist = i;
          end else begin
            if (cache < 0 || last_seen[i] < last_seen[cache]) cache = i;
          end
        end
      end
      if (hist < 0) hist = cache;
      if (hist < 0) begin
        res.status = lkr_pkg::STAT_NOVICTIM;
      end else begin
        untrack(hist);
        res.victim_frame = lkr_pkg::ID_W'(hist);
      end
    end else if (f >= lim) begin
      res.status = lkr_pkg::STAT_RANGE;
    end else if (op.mode == lkr_pkg::MODE_RECORD) begin
      if (tick != '1) tick++;
      if (!trk_valid[f]) begin
        // New frames start evictable with no prior accesses
        trk_valid[f]     = 1'b1;
        trk_evictable[f] = 1'b1;
        hits[f]          = '0;
        first_seen[f]    = tick;
        evictable_num++;
      end
      if (hits[f] != lkr_pkg::ACC_MAX) hits[f]++;
      last_seen[f] = tick;
    end else if (!trk_valid[f]) begin
      res.status = lkr_pkg::STAT_UNTRACKED;
    end else if (op.mode == lkr_pkg::MODE_SET) begin
      if (op.evictable_flag && !trk_evictable[f]) evictable_num++;
      else if (!op.evictable_flag && trk_evictable[f] && evictable_num > 0) evictable_num--;
      trk_evictable[f] = op.evictable_flag;
    end else if (!trk_evictable[f]) begin
      res.status = lkr_pkg::STAT_PINNED;
    end else begin
      untrack(f);
    end
    res.evictable_count = lkr_pkg::COUNT_W'(evictable_num);
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: offer queued operations, predict each one at its transfer.
  // Idle now and then, except for a quiet stretch in the middle of the run.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        outcome_q = {outcome_q, replacer_outcome(cur_op)};
        items_taken++;
      end
      // Hold the payload while a transfer is pending; advance otherwise
      if (!in_ch.valid || in_ch.ready) begin
        if (op_q.size() > 0 &&
            ((items_taken >= 500 && items_taken < 650) || $urandom_range(99) >= 11)) begin
          cur_op               = op_q.pop_front();
          in_ch.valid          <= 1'b1;
          in_ch.mode           <= cur_op.mode;
          in_ch.frame_sel      <= cur_op.frame_sel;
          in_ch.evictable_flag <= cur_op.evictable_flag;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
      err_cnt++;
    end
  endtask

  // ---------------------------------------------------------------------
  // Monitor: compare every result transfer with the oldest prediction.
  // Once, with operations still queued, hold ready low for a long stretch
  // so the block backs up and stalls its input.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (outcome_q.size() == 0) begin
          $display("%0t: result with nothing expected, status %0d victim %0d count %0d",
                   $time, out_ch.status, out_ch.victim_frame, out_ch.evictable_count);
          err_cnt++;
        end else begin
          want = outcome_q.pop_front();
          check_field("status", want.status, out_ch.status);
          check_field("victim_frame", want.victim_frame, out_ch.victim_frame);
          check_field("evictable_count", want.evictable_count, out_ch.evictable_count);
        end
      end
      if (!backlog_done && items_taken >= 300 && op_q.size() > 10) begin
        backlog_done = 1'b1;
        stall_left   = 250;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (results_seen >= 500 && results_seen < 650) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= 11);
      end
    end
  end

  // Append one operation for the driver and count it
  task automatic queue_op(replacer_op_t op);
    op_q = {op_q, op};
    items_queued++;
  endtask

  task automatic push_op(logic [lkr_pkg::MODE_W-1:0] mode, int id, bit flag);
    replacer_op_t op;
    op.mode           = mode;
    op.frame_sel      = lkr_pkg::ID_W'(id);
    op.evictable_flag = flag;
    queue_op(op);
  endtask

  // Mostly hit a small window of in-range frames so counts build up and
  // frames move between history and cache; sprinkle in wild and
  // just-out-of-range ids.
  function automatic replacer_op_t random_op(int lim, int base, int span);
    replacer_op_t op;
    int           roll;
    roll = $urandom_range(99);
    if (roll < 40)      op.mode = lkr_pkg::MODE_RECORD;
    else if (roll < 60) op.mode = lkr_pkg::MODE_SET;
    else if (roll < 75) op.mode = lkr_pkg::MODE_REMOVE;
    else                op.mode = lkr_pkg::MODE_EVICT;
    op.evictable_flag = $urandom_range(1);
    roll = $urandom_range(99);
    if (span > 0 && roll < 85) op.frame_sel = lkr_pkg::ID_W'(base + $urandom_range(span - 1));
    else if (roll < 93)        op.frame_sel = lkr_pkg::ID_W'($urandom_range(255));
    else                       op.frame_sel = lkr_pkg::ID_W'(lim + $urandom_range(3));
    return op;
  endfunction

  // Block until every queued operation has come back as a matched result
  task automatic wait_drained();
    while (results_seen < items_queued || outcome_q.size() != 0) @(posedge clk);
  endtask

  // Write one register; only called while the block is idle
  task automatic write_reg(logic [lkr_pkg::CFG_A_W-1:0] idx,
                           logic [lkr_pkg::CFG_D_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    if (idx == lkr_pkg::CFG_FRAMES_IN_USE) fiu_cfg = data[lkr_pkg::FIU_W-1:0];
    else                                   k_cfg   = data[lkr_pkg::K_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Stimulus: directed checks at the reset settings, then random phases
  // that sweep the limit and the threshold, extremes included.
  // ---------------------------------------------------------------------
  initial begin
    int fiu_set[PHASES];
    int k_set[PHASES];
    int lim;
    int span;
    int base;

    fiu_set   = '{64, 1, 64, 0, 127, 8, 33, 64, 20};
    k_set     = '{2, 1, 15, 0, 3, 1, 15, 0, 2};
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Empty replacer: no victim, untracked frames
    push_op(lkr_pkg::MODE_EVICT, 255, 1'b1);
    push_op(lkr_pkg::MODE_SET, 5, 1'b1);
    push_op(lkr_pkg::MODE_REMOVE, 5, 1'b0);
    // Range edges: last frame in range, first beyond, top id
    push_op(lkr_pkg::MODE_RECORD, 63, 1'b0);
    push_op(lkr_pkg::MODE_RECORD, 64, 1'b1);
    push_op(lkr_pkg::MODE_RECORD, 255, 1'b0);
    push_op(lkr_pkg::MODE_SET, 200, 1'b1);
    push_op(lkr_pkg::MODE_REMOVE, 128, 1'b0);
    // Frame 0 reaches k and becomes cached; 1 and 2 stay in history
    push_op(lkr_pkg::MODE_RECORD, 0, 1'b1);
    push_op(lkr_pkg::MODE_RECORD, 0, 1'b0);
    push_op(lkr_pkg::MODE_RECORD, 1, 1'b0);
    push_op(lkr_pkg::MODE_RECORD, 2, 1'b1);
    // Pin frame 1, try to remove it, pin it again, re-mark an evictable one
    push_op(lkr_pkg::MODE_SET, 1, 1'b0);
    push_op(lkr_pkg::MODE_REMOVE, 1, 1'b1);
    push_op(lkr_pkg::MODE_SET, 1, 1'b0);
    push_op(lkr_pkg::MODE_SET, 2, 1'b1);
    // History frames go first by first access, then the cached one,
    // then nothing is left but the pinned frame
    push_op(lkr_pkg::MODE_EVICT, 0, 1'b0);
    push_op(lkr_pkg::MODE_EVICT, 170, 1'b1);
    push_op(lkr_pkg::MODE_EVICT, 85, 1'b0);
    push_op(lkr_pkg::MODE_EVICT, 1, 1'b1);
    // Unpin and remove
    push_op(lkr_pkg::MODE_SET, 1, 1'b1);
    push_op(lkr_pkg::MODE_REMOVE, 1, 1'b0);
    push_op(lkr_pkg::MODE_REMOVE, 1, 1'b0);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      // Pause the sender here until every result is back, then reconfigure
      write_reg(lkr_pkg::CFG_FRAMES_IN_USE, lkr_pkg::CFG_D_W'(fiu_set[p]));
      write_reg(lkr_pkg::CFG_K_THRESHOLD, {3'($urandom_range(7)), 4'(k_set[p])});
      lim  = (fiu_set[p] > MAX_FRAMES) ? MAX_FRAMES : fiu_set[p];
      span = (lim < 12) ? lim : 12;
      base = (lim > span) ? $urandom_range(lim - span) : 0;
      for (int n = 0; n < PHASE_OPS; n++) queue_op(random_op(lim, base, span));
      wait_drained();
    end

    // Let any stray result show up before the verdict
    repeat (MAX_FRAMES + 8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Bound the run well beyond the slowest legal completion
  initial begin
    #4000000;
    $display("%0t: timeout, %0d results still expected", $time, outcome_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/lkr_pkg.sv
rtl/lkr_in_if.sv
rtl/lkr_out_if.sv
rtl/lkr_victim_sel.sv
rtl/lru_k_frame_replacer_unit.sv
verif/tb_lru_k_frame_replacer_unit.sv
